// ===== rtl/core/trrc_pkg.sv =====
// ----------------------------------------------------------------------------
// trrc_pkg
// Shared types and codes for the torus/ring route-compute block.
// ----------------------------------------------------------------------------
package trrc_pkg;

    localparam int DIV_W     = 9;
    localparam int DIV_CNT_W = 4;
    localparam int REG_IDX_W = 3;
    localparam int CFG_W     = 9;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [REG_IDX_W-1:0] REG_OWN_NODE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NODE_TOTAL  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROUTING_MODE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CLASS_SPLIT = 3'd4;

    localparam logic [1:0] FLIT_HEAD = 2'd0;
    localparam logic [1:0] FLIT_BODY = 2'd1;
    localparam logic [1:0] FLIT_TAIL = 2'd2;
    localparam logic [1:0] FLIT_BAD  = 2'd3;

    localparam logic [1:0] MODE_TORUS = 2'd0;
    localparam logic [1:0] MODE_RING  = 2'd1;
    localparam logic [1:0] MODE_TWO   = 2'd2;

    typedef enum logic [2:0] {
        P_LOCAL = 3'd0,
        P_NORTH = 3'd1,
        P_SOUTH = 3'd2,
        P_EAST  = 3'd3,
        P_WEST  = 3'd4
    } port_t;

    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_NO_ROUTE   = 2'd1,
        ERR_BAD_TYPE   = 2'd2,
        ERR_UNROUTABLE = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        K_HEAD,
        K_BODY,
        K_TAIL,
        K_BAD,
        K_NOCH
    } kind_t;

    typedef struct packed {
        logic [7:0] own_node;
        logic [7:0] row_width;
        logic [8:0] node_total;
        logic [1:0] routing_mode;
        logic       class_split;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [1:0] channel;
        logic [7:0] dst;
        logic       cls;
    } q_item_t;

endpackage

// ===== rtl/core/trrc_div.sv =====
// ----------------------------------------------------------------------------
// trrc_div
// Restoring divider, one quotient bit per cycle, divisor must be nonzero.
// ----------------------------------------------------------------------------
module trrc_div
    import trrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quot,
    output logic [DIV_W-1:0] rem
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     dsr_reg;

    logic [DIV_W:0]   partial;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W-1:0] quo_next;

    always_comb
    begin
        partial  = {rem_reg, quo_reg[DIV_W-1]};
        diff     = partial - {1'b0, dsr_reg};
        ge       = (partial >= {1'b0, dsr_reg});
        rem_next = ge ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/trrc_front.sv =====
// ----------------------------------------------------------------------------
// trrc_front
// Accepts flits, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module trrc_front
    import trrc_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int ID_BITS      = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] channel,
    input  logic [1:0] req_type,
    input  logic [7:0] dest_node,
    input  logic       msg_class,
    output logic       q_valid,
    output q_item_t    q_item,
    input  logic       q_pop
);

    localparam logic [7:0] ID_MASK = (ID_BITS >= 8) ? 8'hFF
                                     : 8'((9'd1 << ID_BITS) - 9'd1);

    q_item_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;

    q_item_t item_in;
    logic    push;
    logic    pop;

    always_comb
    begin
        item_in.channel = channel;
        item_in.dst     = dest_node & ID_MASK;
        item_in.cls     = msg_class;
        priority if (32'(channel) >= NUM_CHANNELS)
        begin
            item_in.kind = K_NOCH;
        end
        else
        begin
            unique case (req_type)
                FLIT_HEAD: item_in.kind = K_HEAD;
                FLIT_BODY: item_in.kind = K_BODY;
                FLIT_TAIL: item_in.kind = K_TAIL;
                FLIT_BAD:  item_in.kind = K_BAD;
            endcase
        end
    end

    assign in_stall = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ===== rtl/core/trrc_back.sv =====
// ----------------------------------------------------------------------------
// trrc_back
// Route sequencer: divides ids into ring coordinates, resolves the port and
// VC, keeps the per-channel routes and drives the result register.
// ----------------------------------------------------------------------------
module trrc_back
    import trrc_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int ID_BITS      = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  q_item_t    q_item,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] hop_port,
    output logic [1:0] out_vc,
    output logic       route_held,
    output logic [1:0] error_code
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [7:0] ID_MASK = (ID_BITS >= 8) ? 8'hFF
                                     : 8'((9'd1 << ID_BITS) - 9'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVA,
        S_DIVB,
        S_EMIT
    } state_t;

    typedef struct packed {
        port_t      port;
        logic [1:0] vc;
    } route_t;

    state_t            state_reg;
    q_item_t           item_reg;
    logic [DIV_W-1:0]  a_q0_reg, a_r0_reg, a_q1_reg, a_r1_reg, a_q2_reg;
    logic [DIV_W-1:0]  b_r0_reg, b_r1_reg;
    logic              route_valid_reg [NUM_CHANNELS];
    port_t             route_port_reg  [NUM_CHANNELS];
    logic [1:0]        route_vc_reg    [NUM_CHANNELS];
    logic              out_valid_reg;
    port_t             hop_port_reg;
    logic [1:0]        out_vc_reg;
    logic              held_reg;
    err_t              err_reg;

    logic [DIV_W-1:0]  me9, w9, n9, ydim;
    logic [DIV_W-1:0]  dvd0, dvd1, dvd2, dsr;
    logic [DIV_W-1:0]  quo0, quo1, quo2, rem0, rem1, rem2;
    logic              done0, done1, done2, div_done;
    logic              div_start, head_div, need_b, emit;
    logic [CH_W-1:0]   idx;
    logic              cur_valid;
    logic [1:0]        lvc;

    route_t            res_route;
    logic              res_held;
    err_t              res_err;
    logic              upd_valid_we;
    logic              upd_valid;
    logic              upd_route_we;

    function automatic route_t ring_route(
        input logic [DIV_W-1:0] me,
        input logic [DIV_W-1:0] dst,
        input logic [DIV_W-1:0] size,
        input logic [DIV_W-1:0] me_m,
        input logic [DIV_W-1:0] dst_m,
        input port_t            fwd,
        input port_t            back,
        input logic             cls,
        input logic             split
    );
        logic [DIV_W-1:0] half;
        logic [DIV_W-1:0] d;
        logic [DIV_W-1:0] m;
        logic             go_back;
        route_t           r;
        half = size >> 1;
        if (dst > me)
        begin
            go_back = ((dst - me) > half);
        end
        else
        begin
            go_back = !((me - dst) > half);
        end
        if (go_back)
        begin
            d = (dst_m == '0) ? '0 : size - dst_m;
            m = (me_m == '0) ? '0 : size - me_m;
            r.port = back;
        end
        else
        begin
            d = dst;
            m = me;
            r.port = fwd;
        end
        if (d > m)
        begin
            r.vc = split ? {1'b1, cls} : 2'd1;
        end
        else
        begin
            r.vc = split ? {1'b0, cls} : 2'd0;
        end
        return r;
    endfunction

    // operands
    always_comb
    begin
        me9  = {1'b0, cfg.own_node & ID_MASK};
        w9   = (cfg.row_width == '0) ? DIV_W'(1) : {1'b0, cfg.row_width};
        n9   = (cfg.node_total == '0) ? DIV_W'(1) : cfg.node_total;
        ydim = (a_q2_reg == '0) ? DIV_W'(1) : a_q2_reg;
        if (state_reg == S_DIVA)
        begin
            dvd0 = quo0;
            dvd1 = quo1;
            dvd2 = quo2;
            dsr  = (quo2 == '0) ? DIV_W'(1) : quo2;
        end
        else if (cfg.routing_mode == MODE_TORUS)
        begin
            dvd0 = me9;
            dvd1 = {1'b0, q_item.dst};
            dvd2 = n9;
            dsr  = w9;
        end
        else
        begin
            dvd0 = me9;
            dvd1 = {1'b0, q_item.dst};
            dvd2 = n9;
            dsr  = n9;
        end
    end

    assign div_done  = done0 && done1 && done2;
    assign head_div  = (q_item.kind == K_HEAD) &&
                       (cfg.routing_mode == MODE_TORUS || cfg.routing_mode == MODE_RING);
    assign need_b    = (cfg.routing_mode == MODE_TORUS) && (rem0 == rem1) && (quo0 != quo1);
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign div_start = (q_pop && head_div) || ((state_reg == S_DIVA) && div_done && need_b);

    trrc_div u_div0 (.clk, .rst_n, .start(div_start), .dividend(dvd0), .divisor(dsr),
                     .done(done0), .quot(quo0), .rem(rem0));
    trrc_div u_div1 (.clk, .rst_n, .start(div_start), .dividend(dvd1), .divisor(dsr),
                     .done(done1), .quot(quo1), .rem(rem1));
    trrc_div u_div2 (.clk, .rst_n, .start(div_start), .dividend(dvd2), .divisor(dsr),
                     .done(done2), .quot(quo2), .rem(rem2));

    // result resolve
    always_comb
    begin
        idx          = CH_W'(item_reg.channel);
        cur_valid    = route_valid_reg[idx];
        lvc          = cfg.class_split ? {1'b0, item_reg.cls} : 2'd0;
        res_route    = '{port: P_LOCAL, vc: 2'd0};
        res_held     = 1'b0;
        res_err      = ERR_OK;
        upd_valid_we = 1'b0;
        upd_valid    = 1'b0;
        upd_route_we = 1'b0;
        unique case (item_reg.kind)
            K_HEAD:
            begin
                res_held     = 1'b1;
                upd_valid_we = 1'b1;
                upd_valid    = 1'b1;
                upd_route_we = 1'b1;
                unique case (cfg.routing_mode)
                    MODE_TORUS:
                    begin
                        if (a_r0_reg == a_r1_reg && a_q0_reg == a_q1_reg)
                        begin
                            res_route = '{port: P_LOCAL, vc: lvc};
                        end
                        else if (a_r0_reg == a_r1_reg)
                        begin
                            res_route = ring_route(a_q0_reg, a_q1_reg, ydim, b_r0_reg,
                                                   b_r1_reg, P_SOUTH, P_NORTH,
                                                   item_reg.cls, cfg.class_split);
                        end
                        else
                        begin
                            res_route = ring_route(a_r0_reg, a_r1_reg, w9, a_r0_reg,
                                                   a_r1_reg, P_EAST, P_WEST,
                                                   item_reg.cls, cfg.class_split);
                        end
                    end
                    MODE_RING:
                    begin
                        if (me9 == {1'b0, item_reg.dst})
                        begin
                            res_route = '{port: P_LOCAL, vc: lvc};
                        end
                        else
                        begin
                            res_route = ring_route(me9, {1'b0, item_reg.dst}, n9, a_r0_reg,
                                                   a_r1_reg, P_EAST, P_WEST,
                                                   item_reg.cls, cfg.class_split);
                        end
                    end
                    MODE_TWO:
                    begin
                        if (me9 == DIV_W'(0))
                        begin
                            res_route.port = (item_reg.dst == 8'd1) ? P_EAST : P_LOCAL;
                            res_route.vc   = lvc;
                        end
                        else if (me9 == DIV_W'(1))
                        begin
                            res_route.port = (item_reg.dst == 8'd0) ? P_WEST : P_LOCAL;
                            res_route.vc   = lvc;
                        end
                        else
                        begin
                            res_held     = 1'b0;
                            res_err      = ERR_UNROUTABLE;
                            upd_valid    = 1'b0;
                            upd_route_we = 1'b0;
                        end
                    end
                    default:
                    begin
                        res_held     = 1'b0;
                        res_err      = ERR_UNROUTABLE;
                        upd_valid    = 1'b0;
                        upd_route_we = 1'b0;
                    end
                endcase
            end
            K_BODY, K_TAIL:
            begin
                if (cur_valid)
                begin
                    res_route = '{port: route_port_reg[idx], vc: route_vc_reg[idx]};
                    res_held  = (item_reg.kind == K_BODY);
                end
                else
                begin
                    res_err = ERR_NO_ROUTE;
                end
                upd_valid_we = (item_reg.kind == K_TAIL);
            end
            K_BAD:
            begin
                res_held = cur_valid;
                res_err  = ERR_BAD_TYPE;
            end
            default:
            begin
                res_err = ERR_NO_ROUTE;
            end
        endcase
    end

    assign emit = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                route_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= head_div ? S_DIVA : S_EMIT;
                    end
                end
                S_DIVA:
                begin
                    if (div_done)
                    begin
                        state_reg <= need_b ? S_DIVB : S_EMIT;
                    end
                end
                S_DIVB:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                        if (upd_valid_we)
                        begin
                            route_valid_reg[idx] <= upd_valid;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == S_DIVA && div_done)
        begin
            a_q0_reg <= quo0;
            a_r0_reg <= rem0;
            a_q1_reg <= quo1;
            a_r1_reg <= rem1;
            a_q2_reg <= quo2;
        end
        if (state_reg == S_DIVB && div_done)
        begin
            b_r0_reg <= rem0;
            b_r1_reg <= rem1;
        end
        if (emit)
        begin
            hop_port_reg <= res_route.port;
            out_vc_reg   <= res_route.vc;
            held_reg     <= res_held;
            err_reg      <= res_err;
            if (upd_route_we)
            begin
                route_port_reg[idx] <= res_route.port;
                route_vc_reg[idx]   <= res_route.vc;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign hop_port   = hop_port_reg;
    assign out_vc     = out_vc_reg;
    assign route_held = held_reg;
    assign error_code = err_reg;

endmodule

// ===== rtl/core/torus_ring_route_compute.sv =====
// ----------------------------------------------------------------------------
// torus_ring_route_compute
// Route compute for one router input port with a stored route per channel.
// ----------------------------------------------------------------------------
// Flits enter a two-entry queue and are handled one at a time. Body, tail,
// invalid-type and out-of-range-channel flits, and head flits in two-node
// mode or an unused mode, pass from the queue through the emit state to the
// result register. A head flit in ring mode, or a torus head that goes
// along X or stays local, runs one pass of three 9-step restoring dividers
// (ids by row width or node count). A torus head that goes along Y needs a
// second divider pass for the Y ring coordinates. A stalled result holds
// back the next one. The divider passes set the rate; the queue and the
// output register let input and output stall independently. Configuration
// must be written only while idle; the block itself does not enforce this.
module torus_ring_route_compute
    import trrc_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int ID_BITS      = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           channel,
    input  logic [1:0]           req_type,
    input  logic [7:0]           dest_node,
    input  logic                 msg_class,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           hop_port,
    output logic [1:0]           out_vc,
    output logic                 route_held,
    output logic [1:0]           error_code
);

    cfg_t    cfg_reg;
    logic    q_valid;
    q_item_t q_item;
    logic    q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_node     <= 8'd0;
            cfg_reg.row_width    <= 8'd4;
            cfg_reg.node_total   <= 9'd16;
            cfg_reg.routing_mode <= MODE_TORUS;
            cfg_reg.class_split  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OWN_NODE:     cfg_reg.own_node     <= cfg_data[7:0];
                REG_ROW_WIDTH:    cfg_reg.row_width    <= cfg_data[7:0];
                REG_NODE_TOTAL:   cfg_reg.node_total   <= cfg_data[8:0];
                REG_ROUTING_MODE: cfg_reg.routing_mode <= cfg_data[1:0];
                REG_CLASS_SPLIT:  cfg_reg.class_split  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    trrc_front #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .ID_BITS     (ID_BITS)
    ) u_front (
        .clk,
        .rst_n,
        .in_valid,
        .in_stall,
        .channel,
        .req_type,
        .dest_node,
        .msg_class,
        .q_valid,
        .q_item,
        .q_pop
    );

    trrc_back #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .clk,
        .rst_n,
        .cfg(cfg_reg),
        .q_valid,
        .q_item,
        .q_pop,
        .out_valid,
        .out_stall,
        .hop_port,
        .out_vc,
        .route_held,
        .error_code
    );

endmodule

// ===== rtl/core/trrc_checker.sv =====
// ----------------------------------------------------------------------------
// trrc_checker
// Port-level checks on the result channel of the route-compute block.
// ----------------------------------------------------------------------------
module trrc_checker
    import trrc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] hop_port,
    input logic [1:0] out_vc,
    input logic       route_held,
    input logic [1:0] error_code
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hop_port) && $stable(out_vc)
                                   && $stable(route_held) && $stable(error_code))
        else $error("result item changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_OK |-> hop_port == P_LOCAL && out_vc == 2'd0)
        else $error("error item carries a route");

    a_noroute_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code == ERR_NO_ROUTE || error_code == ERR_UNROUTABLE)
        |-> !route_held)
        else $error("route held after failed item");

    a_port_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_OK |-> hop_port <= P_WEST && route_held
                                               || hop_port <= P_WEST && !route_held)
        else $error("output port out of range");

endmodule

bind torus_ring_route_compute trrc_checker u_chk (.*);
